/* rtl/core/key_event_to_matrix_macros.svh */
`ifndef KEY_EVENT_TO_MATRIX_MACROS_SVH
`define KEY_EVENT_TO_MATRIX_MACROS_SVH

// check a property on every edge outside reset
`define KEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies another in the next cycle
`define KEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/kem_pkg.sv */
package kem_pkg;

  localparam int unsigned NumRows = 8;
  localparam int unsigned NumCols = 8;
  localparam int unsigned JoyW    = 5;

  localparam logic KindPress   = 1'b0;
  localparam logic KindRelease = 1'b1;

  localparam logic [7:0] CodeStep  = 8'h90;
  localparam logic [7:0] CodeNmi   = 8'h02;
  localparam logic [7:0] CodeFire  = 8'h2A;
  localparam logic [7:0] CodeRight = 8'hFB;
  localparam logic [7:0] CodeDown  = 8'hFE;
  localparam logic [7:0] CodeUp    = 8'hFD;
  localparam logic [7:0] CodeLeft  = 8'hFA;
  localparam logic [7:0] CodeF2    = 8'hF2;
  localparam logic [7:0] CodeF4    = 8'hF4;
  localparam logic [7:0] CodeF6    = 8'hF6;
  localparam logic [7:0] CodeF8    = 8'hF8;

  localparam int unsigned JoyUp    = 0;
  localparam int unsigned JoyDown  = 1;
  localparam int unsigned JoyLeft  = 2;
  localparam int unsigned JoyRight = 3;
  localparam int unsigned JoyFire  = 4;

  localparam logic [2:0] ShiftCol = 3'd7;

  localparam logic [7:0] CodeRom [NumRows][NumCols] = '{
    '{8'h0E, 8'h0A, 8'hFB, 8'hF7, 8'hF1, 8'hF3, 8'hF5, 8'hFE},
    '{8'h33, 8'h57, 8'h41, 8'h34, 8'h5A, 8'h53, 8'h45, 8'h2A},
    '{8'h35, 8'h52, 8'h44, 8'h36, 8'h43, 8'h46, 8'h54, 8'h58},
    '{8'h37, 8'h59, 8'h47, 8'h38, 8'h42, 8'h48, 8'h55, 8'h56},
    '{8'h39, 8'h49, 8'h4A, 8'h30, 8'h4D, 8'h4B, 8'h4F, 8'h4E},
    '{8'h2B, 8'h50, 8'h4C, 8'h2D, 8'h2E, 8'h3B, 8'h5B, 8'h2C},
    '{8'h5C, 8'h5D, 8'h27, 8'hFC, 8'h2A, 8'h3D, 8'h2B, 8'h2F},
    '{8'h31, 8'h60, 8'h1D, 8'h32, 8'h20, 8'hFF, 8'h51, 8'h0F}
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic [63:0]     matrix_bits;
    logic [JoyW-1:0] joystick_bits;
    logic            step_flag;
    logic            nmi_pulse;
  } out_word_t;

  typedef struct packed {
    logic [NumRows-1:0][NumCols-1:0] rows;
    logic [JoyW-1:0]                 joy;
    logic                            step;
  } kem_state_t;

endpackage

/* rtl/core/key_event_to_matrix.sv */
// Key event to keyboard matrix. Each input word is one key press or release with
// an 8-bit host key code; each yields exactly one output word carrying the whole
// 8x8 active-low matrix, the joystick-two bits, the step flag and an NMI pulse.
// Throughput is one word per cycle while the output is not stalled; an accepted
// word sits in the input register and then moves to the output register, with
// the full table compare and state update between the two registers. State is
// updated as a word moves into the output register, so output stall backs up
// into in_stall_o.
module key_event_to_matrix import kem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic       in_valid_q;
  in_word_t   in_word_q;
  logic       out_valid_q;
  out_word_t  out_word_q;
  kem_state_t state_q;
  kem_state_t state_d;
  logic       nmi;
  logic       out_ready;
  logic       advance;
  logic       in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  kem_update u_kem_update (
    .word_i  (in_word_q),
    .state_i (state_q),
    .state_o (state_d),
    .nmi_o   (nmi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{rows: '1, joy: '0, step: 1'b0};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= '{matrix_bits:   state_d.rows,
                      joystick_bits: state_d.joy,
                      step_flag:     state_d.step,
                      nmi_pulse:     nmi};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/core/kem_update.sv */
module kem_update import kem_pkg::*; (
  input  in_word_t   word_i,
  input  kem_state_t state_i,
  output kem_state_t state_o,
  output logic       nmi_o
);

  logic       synth_hit;
  logic [2:0] synth_col;
  logic       release_evt;

  assign release_evt = (word_i.kind == KindRelease);

  always_comb begin
    synth_hit = 1'b1;
    synth_col = 3'd0;
    case (word_i.key_code)
      CodeUp:   synth_col = 3'd7;
      CodeLeft: synth_col = 3'd2;
      CodeF2:   synth_col = 3'd4;
      CodeF4:   synth_col = 3'd5;
      CodeF6:   synth_col = 3'd6;
      CodeF8:   synth_col = 3'd3;
      default:  synth_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_o = state_i;
    nmi_o   = 1'b0;
    if (release_evt) begin
      state_o.joy = '0;
      if (synth_hit) begin
        state_o.rows[0][synth_col] = 1'b1;
        state_o.rows[1][ShiftCol]  = 1'b1;
      end else begin
        for (int r = 0; r < NumRows; r++) begin
          for (int c = 0; c < NumCols; c++) begin
            if (CodeRom[r][c] == word_i.key_code) begin
              state_o.rows[r][c] = 1'b1;
            end
          end
        end
      end
    end else if (word_i.key_code == CodeStep) begin
      state_o.step = ~state_i.step;
    end else if (word_i.key_code == CodeNmi) begin
      nmi_o = 1'b1;
    end else begin
      if (word_i.key_code == CodeFire)  state_o.joy[JoyFire]  = 1'b1;
      if (word_i.key_code == CodeRight) state_o.joy[JoyRight] = 1'b1;
      if (word_i.key_code == CodeDown)  state_o.joy[JoyDown]  = 1'b1;
      if (word_i.key_code == CodeUp)    state_o.joy[JoyUp]    = 1'b1;
      if (word_i.key_code == CodeLeft)  state_o.joy[JoyLeft]  = 1'b1;
      if (synth_hit) begin
        state_o.rows[0][synth_col] = 1'b0;
        state_o.rows[1][ShiftCol]  = 1'b0;
      end else begin
        for (int r = 0; r < NumRows; r++) begin
          for (int c = 0; c < NumCols; c++) begin
            if (CodeRom[r][c] == word_i.key_code) begin
              state_o.rows[r][c] = 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

/* rtl/core/kem_checker.sv */
`include "key_event_to_matrix_macros.svh"

module kem_checker import kem_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  logic in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  `KEM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")
  `KEM_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled while output free")
  `KEM_ASSERT(a_out_origin, $rose(out_valid_o) |-> $past(in_accept, 2), "output word without accepted input")

endmodule

bind key_event_to_matrix kem_checker u_kem_checker (.*);
